FILE: rtl/core/lpe_pkg.sv
// Shared types, widths and constants for the line position estimator.
// No dependencies; every other file in rtl/core refers to this package.
package lpe_pkg;

    // Geometry of the sensor bar
    localparam int SENSOR_COUNT = 8;
    localparam int IDX_W        = $clog2(SENSOR_COUNT);
    localparam int READ_W       = 10;
    localparam int POS_W        = 13;
    localparam int STEP_WEIGHT  = 1000;
    localparam int FAR_END      = (SENSOR_COUNT - 1) * STEP_WEIGHT;
    localparam int MIDDLE       = FAR_END / 2;
    localparam int RESET_POS    = MIDDLE;

    // Accumulator widths: plain sum and index-weighted sum of readings
    localparam int TSUM_W       = READ_W + IDX_W;
    localparam int PROD_W       = READ_W + POS_W;
    localparam int WSUM_W       = PROD_W + IDX_W - 1;

    // Divider: the quotient never exceeds FAR_END, so it fits POS_W bits
    localparam int QUO_W        = POS_W;
    localparam int DIV_CNT_W    = $clog2(QUO_W);

    // Threshold reset values
    localparam logic [READ_W-1:0] LINE_THR_RST  = READ_W'(200);
    localparam logic [READ_W-1:0] NOISE_THR_RST = READ_W'(50);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THR = 1'b1;

    typedef logic [READ_W-1:0] t_reading;
    typedef logic [POS_W-1:0]  t_position;

    typedef struct packed {
        t_reading sensor_0;
        t_reading sensor_1;
        t_reading sensor_2;
        t_reading sensor_3;
        t_reading sensor_4;
        t_reading sensor_5;
        t_reading sensor_6;
        t_reading sensor_7;
    } t_scan;

    typedef struct packed {
        t_position position;
        logic      line_seen;
    } t_result;

    // Divider handshake with the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Weight of sensor k: k times the step weight
    function automatic t_position step_weight(input logic [IDX_W-1:0] k);
        return POS_W'(32'(k) * STEP_WEIGHT);
    endfunction

endpackage

FILE: rtl/core/lpe_accum.sv
// Multiply-accumulate unit: one reading per enabled cycle into plain and weighted sums, if above noise.
// Depends on lpe_pkg.
module lpe_accum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_en,
    input  lpe_pkg::t_reading           i_reading,
    input  logic [lpe_pkg::IDX_W-1:0]   i_idx,
    input  lpe_pkg::t_reading           i_line_thr,
    input  lpe_pkg::t_reading           i_noise_thr,
    output logic [lpe_pkg::WSUM_W-1:0]  o_wsum,
    output logic [lpe_pkg::TSUM_W-1:0]  o_tsum,
    output logic                        o_seen
);

    logic [lpe_pkg::WSUM_W-1:0] r_wsum;
    logic [lpe_pkg::TSUM_W-1:0] r_tsum;
    logic                       r_seen;
    logic [lpe_pkg::PROD_W-1:0] w_prod;
    logic                       w_above_noise;

    // Weight the reading by its sensor position
    assign w_prod        = lpe_pkg::PROD_W'(i_reading) *
                           lpe_pkg::PROD_W'(lpe_pkg::step_weight(i_idx));
    assign w_above_noise = i_reading > i_noise_thr;

    // Clear on a new scan, accumulate one reading per enabled cycle when above the noise threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_wsum <= '0;
            r_tsum <= '0;
        end else if (i_clear) begin
            r_seen <= 1'b0;
            r_wsum <= '0;
            r_tsum <= '0;
        end else if (i_en) begin
            if (i_reading > i_line_thr) begin
                r_seen <= 1'b1;
            end
            if (w_above_noise) begin
                r_wsum <= r_wsum + lpe_pkg::WSUM_W'(w_prod);
                r_tsum <= r_tsum + lpe_pkg::TSUM_W'(i_reading);
            end
        end
    end

    assign o_wsum = r_wsum;
    assign o_tsum = r_tsum;
    assign o_seen = r_seen;

endmodule

FILE: rtl/core/lpe_div.sv
// Restoring serial divider: one quotient bit per cycle, weighted sum by plain sum.
// Depends on lpe_pkg.
module lpe_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lpe_pkg::WSUM_W-1:0]  i_dividend,
    input  logic [lpe_pkg::TSUM_W-1:0]  i_divisor,
    output lpe_pkg::t_div_stat          o_stat,
    output lpe_pkg::t_position          o_quotient
);

    localparam int HI_W = lpe_pkg::WSUM_W - lpe_pkg::QUO_W;
    localparam logic [lpe_pkg::DIV_CNT_W-1:0] LAST_STEP =
        lpe_pkg::DIV_CNT_W'(lpe_pkg::QUO_W - 1);

    logic                            r_busy;
    logic [lpe_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [lpe_pkg::TSUM_W-1:0]      r_rem;
    logic [lpe_pkg::QUO_W-1:0]       r_shq;
    logic [lpe_pkg::TSUM_W-1:0]      r_dvs;
    logic [lpe_pkg::TSUM_W:0]        w_trial;
    logic                            w_fit;

    // Bring down the next dividend bit and try a subtract
    assign w_trial = {r_rem, r_shq[lpe_pkg::QUO_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    // The high dividend bits are below the divisor since the quotient fits QUO_W bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Shift the quotient into the low dividend bits as they are consumed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= lpe_pkg::TSUM_W'(i_dividend[lpe_pkg::WSUM_W-1 -: HI_W]);
            r_shq <= i_dividend[lpe_pkg::QUO_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= lpe_pkg::TSUM_W'(w_trial - {1'b0, r_dvs});
            end else begin
                r_rem <= lpe_pkg::TSUM_W'(w_trial);
            end
            r_shq <= {r_shq[lpe_pkg::QUO_W-2:0], w_fit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == LAST_STEP);
    assign o_quotient  = r_shq;

endmodule

FILE: rtl/core/line_position_estimator.sv
// Line position estimator: weighted centroid of eight reflectance readings.
// Each accepted scan steps through ST_ACC, ST_CHK, ST_DIV (skipped when no reading is above noise) and ST_FIN:
// one reading per cycle through the shared multiply-accumulate, one quotient bit per cycle.
// A new scan is accepted only in idle, after the last result is registered; an output stall holds it in ST_FIN.
// Reset (synchronous, active low): thresholds 200 and 50, stored position 3500, idle.
// Depends on lpe_pkg, lpe_accum, lpe_div.
module line_position_estimator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_scan_valid,
    output logic                              o_scan_ready,
    input  lpe_pkg::t_scan                    i_scan,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output lpe_pkg::t_result                  o_res,
    input  logic                              i_cfg_we,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lpe_pkg::READ_W-1:0]        i_cfg_data
);

    localparam logic [lpe_pkg::IDX_W-1:0] LAST_IDX =
        lpe_pkg::IDX_W'(lpe_pkg::SENSOR_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHK,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state                          r_state;
    logic [lpe_pkg::IDX_W-1:0]       r_idx;
    lpe_pkg::t_reading               r_scan [lpe_pkg::SENSOR_COUNT];
    lpe_pkg::t_reading               r_line_thr;
    lpe_pkg::t_reading               r_noise_thr;
    lpe_pkg::t_position              r_last_pos;
    logic                            r_res_valid;
    lpe_pkg::t_result                r_res;

    logic                            w_accept;
    logic                            w_out_free;
    logic [lpe_pkg::WSUM_W-1:0]      w_wsum;
    logic [lpe_pkg::TSUM_W-1:0]      w_tsum;
    logic                            w_seen;
    lpe_pkg::t_div_stat              w_div_stat;
    lpe_pkg::t_position              w_quotient;
    lpe_pkg::t_position              w_snap;
    lpe_pkg::t_position              n_pos;

    assign o_scan_ready = (r_state == ST_IDLE);
    assign w_accept     = i_scan_valid && o_scan_ready;
    assign w_out_free   = !r_res_valid || i_res_ready;

    // Threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_thr  <= lpe_pkg::LINE_THR_RST;
            r_noise_thr <= lpe_pkg::NOISE_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lpe_pkg::CFG_LINE_THR:  r_line_thr  <= i_cfg_data;
                lpe_pkg::CFG_NOISE_THR: r_noise_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the scan on acceptance
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_scan[0] <= i_scan.sensor_0;
            r_scan[1] <= i_scan.sensor_1;
            r_scan[2] <= i_scan.sensor_2;
            r_scan[3] <= i_scan.sensor_3;
            r_scan[4] <= i_scan.sensor_4;
            r_scan[5] <= i_scan.sensor_5;
            r_scan[6] <= i_scan.sensor_6;
            r_scan[7] <= i_scan.sensor_7;
        end
    end

    lpe_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_accept),
        .i_en        (r_state == ST_ACC),
        .i_reading   (r_scan[r_idx]),
        .i_idx       (r_idx),
        .i_line_thr  (r_line_thr),
        .i_noise_thr (r_noise_thr),
        .o_wsum      (w_wsum),
        .o_tsum      (w_tsum),
        .o_seen      (w_seen)
    );

    lpe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == ST_CHK) && (w_tsum != '0)),
        .i_dividend (w_wsum),
        .i_divisor  (w_tsum),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    // Snap to the nearer end when the line is lost, then let the centroid override
    assign w_snap = w_seen ? r_last_pos :
                    (r_last_pos < lpe_pkg::POS_W'(lpe_pkg::MIDDLE)) ? '0 :
                    lpe_pkg::POS_W'(lpe_pkg::FAR_END);
    assign n_pos  = (w_tsum != '0) ? w_quotient : w_snap;

    // Sequencer, stored position and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_last_pos  <= lpe_pkg::POS_W'(lpe_pkg::RESET_POS);
            r_res_valid <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one replaces it this cycle
            if (r_res_valid && i_res_ready && (r_state != ST_FIN)) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_idx   <= '0;
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    r_state <= (w_tsum != '0) ? ST_DIV : ST_FIN;
                end
                ST_DIV: begin
                    if (w_div_stat.done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_last_pos      <= n_pos;
                        r_res.position  <= n_pos;
                        r_res.line_seen <= w_seen;
                        r_res_valid     <= 1'b1;
                        r_state         <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_pos <= lpe_pkg::POS_W'(lpe_pkg::FAR_END))
        else $error("stored position beyond far end");

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> (r_state == ST_DIV))
        else $error("divider running outside the divide state");

    a_result_matches_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> (r_res.position == r_last_pos))
        else $error("result position differs from stored position");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && r_res_valid && !i_res_ready |=> (r_state == ST_FIN))
        else $error("pending result overwritten");
`endif

endmodule
